// ----- hdl/ffsa_pkg.sv -----
// Package for the first-fit segment allocator: sizes, status codes, cell types.
// Used by ffsa_cell and first_fit_segment_allocator; depends on nothing.
package ffsa_pkg;
  localparam int POOL_BYTES   = 65536;
  localparam int HEADER_BYTES = 16;
  localparam int MAX_SEGMENTS = 16;
  localparam int AW = 17;
  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [AW-1:0] HDR = AW'(HEADER_BYTES);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FIT   = 2'd1,
    ST_FULL     = 2'd2,
    ST_BAD_FREE = 2'd3
  } status_t;

  typedef struct packed {
    logic [AW-1:0] start;
    logic [AW-1:0] payload;
    logic          is_free;
  } seg_t;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_SET,
    CMD_LEFT,
    CMD_RIGHT
  } cmd_t;

  typedef struct packed {
    cmd_t          cmd;
    seg_t          wdata;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SEARCH, S_ALLOC, S_FREE_NEXT, S_FREE_PREV, S_RESULT
  } fsm_t;
endpackage

// ----- hdl/first_fit_segment_allocator.sv -----
// First-fit segment allocator: a row of segment cells driven by a sequencer.
// An allocate passes through the states search, alloc and result; a free
// through search, free-next, free-prev and result; a refused request (no
// fit, table full, bad free) goes from search straight to result.
// Throughput: one request at a time; the next request is taken the cycle after
// the result is accepted, so result stalls delay it. The search step is a
// parallel match plus priority pick; alloc shifts, free-next/free-prev merge.
// Reset: rst_n synchronous; table holds one free segment spanning the pool.
module first_fit_segment_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [15:0] in_request_size,
  input  logic [15:0] in_release_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [15:0] out_payload_offset
);
  localparam int N  = ffsa_pkg::MAX_SEGMENTS;
  localparam int AW = ffsa_pkg::AW;
  localparam int IW = ffsa_pkg::IW;
  localparam int CW = ffsa_pkg::CW;

  ffsa_pkg::fsm_t      state_r, state_nxt;
  ffsa_pkg::seg_t      segs [N];
  ffsa_pkg::cell_ctl_t ctl [N];
  logic [CW-1:0]       count_r, count_nxt;
  logic                func_r;
  logic [15:0]         size_r, rel_r;
  logic [IW-1:0]       hit_r, hit_nxt;
  logic [1:0]          status_r, status_nxt;
  logic [15:0]         off_r, off_nxt;
  logic                captured;

  // Cell row; entry 0 resets to one free segment covering the pool.
  for (genvar g = 0; g < N; g++) begin : g_cell
    ffsa_pkg::seg_t rv, fl, fr;
    assign rv.start   = '0;
    assign rv.payload = (g == 0) ? AW'(ffsa_pkg::POOL_BYTES - ffsa_pkg::HEADER_BYTES) : '0;
    assign rv.is_free = (g == 0);
    assign fl = (g == 0) ? '0 : segs[(g == 0) ? 0 : g-1];
    assign fr = (g == N-1) ? '0 : segs[(g == N-1) ? g : g+1];
    ffsa_cell u_cell (
      .clk(clk), .rst_n(rst_n), .reset_val(rv), .ctl(ctl[g]),
      .from_left(fl), .from_right(fr), .seg(segs[g])
    );
  end

  // Parallel match over the row; first match wins.
  logic [N-1:0] match;
  logic [AW-1:0] need;
  assign need = AW'(size_r) + ffsa_pkg::HDR;
  always_comb begin
    for (int i = 0; i < N; i++) begin
      if (!func_r) begin
        match[i] = (i < count_r) && segs[i].is_free && (need <= segs[i].payload);
      end else begin
        match[i] = (i < count_r) && !segs[i].is_free &&
                   ((segs[i].start + ffsa_pkg::HDR) == AW'(rel_r));
      end
    end
  end

  logic          any_match;
  logic [IW-1:0] first_idx;
  always_comb begin
    any_match = 1'b0;
    first_idx = '0;
    for (int i = N-1; i >= 0; i--) begin
      if (match[i]) begin
        any_match = 1'b1;
        first_idx = IW'(i);
      end
    end
  end

  ffsa_pkg::seg_t hseg, nseg;
  assign hseg = segs[hit_r];
  assign nseg = segs[(hit_r == IW'(N-1)) ? hit_r : hit_r + 1'b1];

  assign in_ready  = (state_r == ffsa_pkg::S_IDLE);
  assign captured  = in_valid && in_ready;
  assign out_valid = (state_r == ffsa_pkg::S_RESULT);
  assign out_status = status_r;
  assign out_payload_offset = off_r;

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    hit_nxt    = hit_r;
    status_nxt = status_r;
    off_nxt    = off_r;
    for (int i = 0; i < N; i++) begin
      ctl[i].cmd   = ffsa_pkg::CMD_HOLD;
      ctl[i].wdata = segs[i];
    end
    case (state_r)
      ffsa_pkg::S_IDLE: begin
        if (captured) state_nxt = ffsa_pkg::S_SEARCH;
      end
      ffsa_pkg::S_SEARCH: begin
        hit_nxt    = first_idx;
        off_nxt    = '0;
        status_nxt = ffsa_pkg::ST_OK;
        if (!any_match) begin
          status_nxt = func_r ? ffsa_pkg::ST_BAD_FREE : ffsa_pkg::ST_NO_FIT;
          state_nxt  = ffsa_pkg::S_RESULT;
        end else if (!func_r && count_r >= CW'(N)) begin
          status_nxt = ffsa_pkg::ST_FULL;
          state_nxt  = ffsa_pkg::S_RESULT;
        end else if (!func_r) begin
          state_nxt = ffsa_pkg::S_ALLOC;
        end else begin
          // Mark free now; merges follow.
          ctl[first_idx].cmd           = ffsa_pkg::CMD_SET;
          ctl[first_idx].wdata.is_free = 1'b1;
          state_nxt = ffsa_pkg::S_FREE_NEXT;
        end
      end
      ffsa_pkg::S_ALLOC: begin
        // Open a slot after hit: shift cells above hit right by one.
        for (int i = 0; i < N; i++) begin
          if (i > hit_r + 1 && i <= count_r) ctl[i].cmd = ffsa_pkg::CMD_LEFT;
        end
        ctl[hit_r].cmd             = ffsa_pkg::CMD_SET;
        ctl[hit_r].wdata.start     = hseg.start;
        ctl[hit_r].wdata.payload   = AW'(size_r);
        ctl[hit_r].wdata.is_free   = 1'b0;
        ctl[hit_r + 1'b1].cmd           = ffsa_pkg::CMD_SET;
        ctl[hit_r + 1'b1].wdata.start   = hseg.start + need;
        ctl[hit_r + 1'b1].wdata.payload = hseg.payload - need;
        ctl[hit_r + 1'b1].wdata.is_free = 1'b1;
        count_nxt = count_r + 1'b1;
        off_nxt   = 16'(hseg.start + ffsa_pkg::HDR);
        state_nxt = ffsa_pkg::S_RESULT;
      end
      ffsa_pkg::S_FREE_NEXT: begin
        // Absorb a free right neighbor and drop its entry.
        if (CW'(hit_r) + 1'b1 < count_r && nseg.is_free) begin
          ctl[hit_r].cmd           = ffsa_pkg::CMD_SET;
          ctl[hit_r].wdata.payload = hseg.payload + ffsa_pkg::HDR + nseg.payload;
          for (int i = 0; i < N; i++) begin
            if (i > hit_r && i < count_r) begin
              ctl[i].cmd = (i + 1 < count_r) ? ffsa_pkg::CMD_RIGHT : ffsa_pkg::CMD_SET;
              if (i + 1 >= count_r) ctl[i].wdata = '0;
            end
          end
          count_nxt = count_r - 1'b1;
        end
        state_nxt = ffsa_pkg::S_FREE_PREV;
      end
      ffsa_pkg::S_FREE_PREV: begin
        // Let the left neighbor absorb this entry if it is free.
        if (hit_r != '0 && segs[hit_r - 1'b1].is_free) begin
          ctl[hit_r - 1'b1].cmd           = ffsa_pkg::CMD_SET;
          ctl[hit_r - 1'b1].wdata.payload = segs[hit_r - 1'b1].payload +
                                            ffsa_pkg::HDR + hseg.payload;
          for (int i = 0; i < N; i++) begin
            if (i >= hit_r && i < count_r) begin
              ctl[i].cmd = (i + 1 < count_r) ? ffsa_pkg::CMD_RIGHT : ffsa_pkg::CMD_SET;
              if (i + 1 >= count_r) ctl[i].wdata = '0;
            end
          end
          count_nxt = count_r - 1'b1;
        end
        state_nxt = ffsa_pkg::S_RESULT;
      end
      ffsa_pkg::S_RESULT: begin
        if (out_ready) state_nxt = ffsa_pkg::S_IDLE;
      end
      default: state_nxt = ffsa_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffsa_pkg::S_IDLE;
      count_r <= CW'(1);
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Hold the request and the result payload.
  always_ff @(posedge clk) begin
    if (captured) begin
      func_r <= in_func;
      size_r <= in_request_size;
      rel_r  <= in_release_offset;
    end
    hit_r    <= hit_nxt;
    status_r <= status_nxt;
    off_r    <= off_nxt;
  end
endmodule

// ----- hdl/ffsa_cell.sv -----
// One segment-table cell: holds one entry and shifts it to or from a neighbor.
// Depends on ffsa_pkg.
module ffsa_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  ffsa_pkg::seg_t      reset_val,
  input  ffsa_pkg::cell_ctl_t ctl,
  input  ffsa_pkg::seg_t      from_left,
  input  ffsa_pkg::seg_t      from_right,
  output ffsa_pkg::seg_t      seg
);
  ffsa_pkg::seg_t seg_r, seg_nxt;
  assign seg = seg_r;

  always_comb begin
    case (ctl.cmd)
      ffsa_pkg::CMD_SET:   seg_nxt = ctl.wdata;
      ffsa_pkg::CMD_LEFT:  seg_nxt = from_left;
      ffsa_pkg::CMD_RIGHT: seg_nxt = from_right;
      default:             seg_nxt = seg_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r <= reset_val;
    end else begin
      seg_r <= seg_nxt;
    end
  end
endmodule
